FILE: hw/rtl/yqrgb_pkg.sv
// ----------------------------------------------------------------------------
// yqrgb_pkg
// Shared types, register codes and conversion tables for the 2x2 quad
// yuv420 to rgb converter.
// ----------------------------------------------------------------------------
package yqrgb_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OUTPUT_MODE   = 2'd0,
    CFG_PREMULTIPLY   = 2'd1,
    CFG_CHANNEL_ORDER = 2'd2
  } cfg_idx_e;

  // output modes, the reserved code behaves as three-byte rgb
  typedef enum logic [1:0] {
    MODE_XRGB  = 2'd0,
    MODE_RGB   = 2'd1,
    MODE_SPLIT = 2'd2
  } mode_e;

  typedef enum logic {
    ORDER_BGR = 1'b0,
    ORDER_RGB = 1'b1
  } order_e;

  localparam int unsigned RomW   = 24;
  localparam int unsigned SumW   = RomW + 1;
  localparam int unsigned FracW  = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PixelW = 32;

  typedef logic signed [RomW-1:0] rom_t [256];

  // live configuration
  typedef struct packed {
    logic [1:0] mode;
    logic       premul;
    order_e     order;
  } cfg_t;

  // chroma terms shared by the four lanes
  typedef struct packed {
    logic signed [RomW-1:0] rv;
    logic signed [RomW-1:0] guv;
    logic signed [RomW-1:0] bu;
    logic signed [RomW-1:0] arv;
  } chroma_t;

  // stage load enables
  typedef struct packed {
    logic en1;
    logic en2;
  } pipe_ctrl_t;

  // round to 24 significant bits, nearest even
  function automatic logic [63:0] round_sig24(logic [63:0] x);
    int unsigned k;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    k = 0;
    for (int i = 0; i < 40; i++) begin
      if ((x >> k) >= 64'd16777216) k++;
    end
    if (k == 0) return x;
    q    = x >> k;
    rem  = x & ((64'd1 << k) - 64'd1);
    half = 64'd1 << (k - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q << k;
  endfunction

  // one table entry, single precision product and difference
  function automatic logic signed [RomW-1:0] rom_entry(logic [63:0] mant, int unsigned frac,
                                                       logic [63:0] centre, int unsigned idx);
    logic [63:0] prod;
    logic [63:0] mid;
    logic [63:0] mag;
    logic        neg;
    prod = round_sig24(mant * 64'(idx));
    mid  = mant * centre;
    if (prod >= mid) begin
      mag = prod - mid;
      neg = 1'b0;
    end else begin
      mag = mid - prod;
      neg = 1'b1;
    end
    mag = round_sig24(mag) >> frac;
    return neg ? -$signed(mag[RomW-1:0]) : $signed(mag[RomW-1:0]);
  endfunction

  function automatic rom_t gen_rom(logic [63:0] mant, int unsigned frac, logic [63:0] centre);
    rom_t t;
    for (int i = 0; i < 256; i++) t[i] = rom_entry(mant, frac, centre, i);
    return t;
  endfunction

  // tables, built at elaboration
  localparam rom_t Y_ROM  = gen_rom(64'd9764852, 10, 64'd16);
  localparam rom_t RV_ROM = gen_rom(64'd13388730, 10, 64'd128);
  localparam rom_t GU_ROM = gen_rom(64'd13121831, 12, 64'd128);
  localparam rom_t GV_ROM = gen_rom(64'd13640901, 11, 64'd128);
  localparam rom_t BU_ROM = gen_rom(64'd8464361, 9, 64'd128);

  // floor shift by the fraction bits, clamped to a byte
  function automatic logic [ByteW-1:0] shift_clamp(logic signed [SumW-1:0] x);
    logic signed [SumW-FracW-1:0] s;
    s = x[SumW-1:FracW];
    if (s < 0) return '0;
    if (s > 255) return 8'hFF;
    return s[ByteW-1:0];
  endfunction

endpackage

FILE: hw/rtl/yqrgb_chroma.sv
// ----------------------------------------------------------------------------
// yqrgb_chroma
// Looks up the chroma table terms of one quad and registers them for the
// lanes.
// ----------------------------------------------------------------------------
module yqrgb_chroma (
  input  logic                  clk_i,
  input  yqrgb_pkg::pipe_ctrl_t ctrl_i,
  input  logic [7:0]            chroma_u_i,
  input  logic [7:0]            chroma_v_i,
  input  logic [7:0]            alpha_chroma_v_i,
  output yqrgb_pkg::chroma_t    chroma_o
);

  yqrgb_pkg::chroma_t chroma_d;
  yqrgb_pkg::chroma_t chroma_q;

  // table reads, green terms merged
  always_comb begin
    chroma_d.rv  = yqrgb_pkg::RV_ROM[chroma_v_i];
    chroma_d.guv = yqrgb_pkg::GU_ROM[chroma_u_i] + yqrgb_pkg::GV_ROM[chroma_v_i];
    chroma_d.bu  = yqrgb_pkg::BU_ROM[chroma_u_i];
    chroma_d.arv = yqrgb_pkg::RV_ROM[alpha_chroma_v_i];
  end

  // first stage register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      chroma_q <= chroma_d;
    end
  end

  assign chroma_o = chroma_q;

endmodule

FILE: hw/rtl/yqrgb_lane.sv
// ----------------------------------------------------------------------------
// yqrgb_lane
// One pixel of the quad: luma lookup, channel sums with clamp, alpha,
// optional premultiply and byte packing.
// ----------------------------------------------------------------------------
module yqrgb_lane (
  input  logic                  clk_i,
  input  yqrgb_pkg::pipe_ctrl_t ctrl_i,
  input  yqrgb_pkg::cfg_t       cfg_i,
  input  logic [7:0]            luma_i,
  input  logic [7:0]            alpha_luma_i,
  input  yqrgb_pkg::chroma_t    chroma_i,
  output logic [31:0]           pixel_o
);

  logic signed [yqrgb_pkg::RomW-1:0] y_q;
  logic signed [yqrgb_pkg::RomW-1:0] ay_q;
  logic signed [yqrgb_pkg::SumW-1:0] r_sum;
  logic signed [yqrgb_pkg::SumW-1:0] g_sum;
  logic signed [yqrgb_pkg::SumW-1:0] b_sum;
  logic signed [yqrgb_pkg::SumW-1:0] a_sum;
  logic [7:0] r_d, g_d, b_d, a_d;
  logic [7:0] r_q, g_q, b_q, a_q;
  logic [7:0] r_p, g_p, b_p;
  logic       premul_on;

  // floor(p / 255) for p up to 255 * 255
  function automatic logic [7:0] div255(logic [15:0] p);
    logic [16:0] t;
    t = 17'(p) + 17'(p >> 8) + 17'd1;
    return t[15:8];
  endfunction

  // stage one: luma lookups
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      y_q  <= yqrgb_pkg::Y_ROM[luma_i];
      ay_q <= yqrgb_pkg::Y_ROM[alpha_luma_i];
    end
  end

  // stage two: channel sums
  assign r_sum = yqrgb_pkg::SumW'(y_q) + yqrgb_pkg::SumW'(chroma_i.rv);
  assign g_sum = yqrgb_pkg::SumW'(y_q) - yqrgb_pkg::SumW'(chroma_i.guv);
  assign b_sum = yqrgb_pkg::SumW'(y_q) + yqrgb_pkg::SumW'(chroma_i.bu);
  assign a_sum = yqrgb_pkg::SumW'(ay_q) + yqrgb_pkg::SumW'(chroma_i.arv);

  always_comb begin
    r_d = yqrgb_pkg::shift_clamp(r_sum);
    g_d = yqrgb_pkg::shift_clamp(g_sum);
    b_d = yqrgb_pkg::shift_clamp(b_sum);
    case (cfg_i.mode)
      yqrgb_pkg::MODE_XRGB:  a_d = 8'hFF;
      yqrgb_pkg::MODE_SPLIT: a_d = yqrgb_pkg::shift_clamp(a_sum);
      default:               a_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
      a_q <= a_d;
    end
  end

  // premultiply in split alpha mode only
  assign premul_on = (cfg_i.mode == yqrgb_pkg::MODE_SPLIT) && cfg_i.premul;

  always_comb begin
    if (premul_on) begin
      r_p = div255(16'(r_q) * 16'(a_q));
      g_p = div255(16'(g_q) * 16'(a_q));
      b_p = div255(16'(b_q) * 16'(a_q));
    end else begin
      r_p = r_q;
      g_p = g_q;
      b_p = b_q;
    end
  end

  // byte packing, alpha in byte three
  always_comb begin
    case (cfg_i.order)
      yqrgb_pkg::ORDER_RGB: pixel_o = {a_q, b_p, g_p, r_p};
      default:              pixel_o = {a_q, r_p, g_p, b_p};
    endcase
  end

endmodule

FILE: hw/rtl/yuv420_quad_to_rgb_top.sv
// Pipeline: two table/sum stages and the output register from input
// transfer to result valid. Throughput: one quad per cycle unless the
// output stalls; all four pixels run in parallel lanes.
// The input is taken whenever a pipeline stage ahead has room.
// Reset: clears stage valids; output_mode 1, premultiply 0, channel_order 0.
// ----------------------------------------------------------------------------
// yuv420_quad_to_rgb_top
// Converts a 2x2 luma quad with shared chroma to four packed pixels, with
// optional split alpha taken from the lower half of the frame.
// ----------------------------------------------------------------------------
module yuv420_quad_to_rgb_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: luma_top_left, luma_top_right, luma_bottom_left,
  // luma_bottom_right, chroma_u, chroma_v, alpha_luma_top_left,
  // alpha_luma_top_right, alpha_luma_bottom_left, alpha_luma_bottom_right,
  // alpha_chroma_v (8 bits each)
  input  logic [87:0]  s_axis_tdata,
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: pixel_top_left, pixel_top_right, pixel_bottom_left,
  // pixel_bottom_right (32 bits each)
  output logic [127:0] m_axis_tdata,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [1:0]   cfg_data_i
);

  localparam int unsigned Lanes = 4;

  yqrgb_pkg::cfg_t       cfg_q;
  yqrgb_pkg::pipe_ctrl_t ctrl;
  yqrgb_pkg::chroma_t    chroma;
  logic                  v1_q, v2_q, vo_q;
  logic                  en3;
  logic [31:0]           pixel [Lanes];
  logic [127:0]          out_d;
  logic [127:0]          out_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= yqrgb_pkg::MODE_RGB;
      cfg_q.premul <= 1'b0;
      cfg_q.order  <= yqrgb_pkg::ORDER_BGR;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        yqrgb_pkg::CFG_OUTPUT_MODE:   cfg_q.mode   <= cfg_data_i;
        yqrgb_pkg::CFG_PREMULTIPLY:   cfg_q.premul <= cfg_data_i[0];
        yqrgb_pkg::CFG_CHANNEL_ORDER: cfg_q.order  <= yqrgb_pkg::order_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // stage advance, a stage loads when it is empty or moves on
  assign en3      = !vo_q || m_axis_tready;
  assign ctrl.en2 = !v2_q || en3;
  assign ctrl.en1 = !v1_q || ctrl.en2;
  assign s_axis_tready = ctrl.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ctrl.en1) v1_q <= s_axis_tvalid;
      if (ctrl.en2) v2_q <= v1_q;
      if (en3)      vo_q <= v2_q;
    end
  end

  // shared chroma terms
  yqrgb_chroma u_chroma (
    .clk_i            (clk_i),
    .ctrl_i           (ctrl),
    .chroma_u_i       (s_axis_tdata[39:32]),
    .chroma_v_i       (s_axis_tdata[47:40]),
    .alpha_chroma_v_i (s_axis_tdata[87:80]),
    .chroma_o         (chroma)
  );

  // one lane per pixel of the quad
  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    yqrgb_lane u_lane (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .cfg_i        (cfg_q),
      .luma_i       (s_axis_tdata[8*k +: 8]),
      .alpha_luma_i (s_axis_tdata[48 + 8*k +: 8]),
      .chroma_i     (chroma),
      .pixel_o      (pixel[k])
    );
  end

  // merge lanes into the output register
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      out_d[32*k +: 32] = pixel[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

  // accepted quad lands in stage one
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted quad lost before stage one");

  // stalled stage one keeps its quad
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !ctrl.en1 |=> v1_q)
    else $error("stage one dropped a stalled quad");

  // stalled stage two keeps its quad
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !ctrl.en2 |=> v2_q)
    else $error("stage two dropped a stalled quad");

  // a new result only comes from a filled stage two
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v2_q))
    else $error("result raised without a quad in stage two");

endmodule
